/* design/pmn_pkg.sv */
// pointer motion normalizer package: field codes, item and state types
// used by pmn_cfg, pmn_calc and pointer_motion_normalizer
`timescale 1ns / 1ps

package pmn_pkg;

    localparam logic [1:0] KIND_MOUSE = 2'd0;
    localparam logic [1:0] KIND_POLL  = 2'd1;

    localparam logic [1:0] AXIS_X       = 2'd0;
    localparam logic [1:0] AXIS_Y       = 2'd1;
    localparam logic [1:0] AXIS_XY      = 2'd2;
    localparam logic [1:0] AXIS_UNKNOWN = 2'd3;

    localparam logic [1:0] CFG_WANT_RELATIVE  = 2'd0;
    localparam logic [1:0] CFG_NO_CLAMP       = 2'd1;
    localparam logic [1:0] CFG_SURFACE_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_SURFACE_HEIGHT = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef struct packed {
        logic        want_relative;
        logic        no_clamp;
        logic [15:0] surface_width;
        logic [15:0] surface_height;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         axis_code;
        logic               sample_relative;
        logic signed [15:0] first_value;
        logic signed [15:0] second_value;
    } item_t;

    typedef struct packed {
        logic               tracking_relative;
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
        logic signed [31:0] previous_x;
        logic signed [31:0] previous_y;
    } state_t;

    typedef struct packed {
        logic               moved;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
    } result_t;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31])
        begin
            r = v[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_axis(input logic signed [31:0] v,
                                                      input logic no_clamp,
                                                      input logic [15:0] bound);
        logic signed [31:0] r;
        if (no_clamp)
        begin
            r = v;
        end
        else if (v[31])
        begin
            r = '0;
        end
        else if (v[30:0] > {15'd0, bound})
        begin
            r = {16'd0, bound};
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sext16(input logic signed [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

/* design/pointer_motion_normalizer.sv */
// pointer motion normalizer top level: input register, state and result register
// depends on pmn_pkg, pmn_cfg and pmn_calc
`timescale 1ns / 1ps

// Converts pointer items (mouse samples flagged relative or absolute, polls,
// foreign items) into either motion deltas or surface-clamped positions, one
// result item per input item. An accepted item waits in an input register,
// is processed combinationally against the tracked position and history,
// and lands in an output register, so one item per cycle is sustained while
// the output is not stalled. The rate is limited only by output back-pressure
// and the combinational state update loop of the calc stage. Configuration
// writes take effect on the next cycle and should be made while idle.
module pointer_motion_normalizer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,  // first_value, second_value
    input  logic [4:0]                      s_axis_tuser,  // kind, axis_code, sample_relative
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [63:0]                     m_axis_tdata,  // out_x, out_y
    output logic [0:0]                      m_axis_tuser,  // moved
    input  logic                            cfg_we,
    input  logic [pmn_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pmn_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pmn_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_vld_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    result_t out_res_reg;
    logic    out_vld_reg;
    logic    adv;

    pmn_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pmn_calc u_calc (
        .cfg  (cfg),
        .item (in_item_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    assign adv           = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_vld_reg <= s_axis_tvalid;
            end
            if (adv)
            begin
                state_reg   <= state_next;
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.kind            <= s_axis_tuser[1:0];
            in_item_reg.axis_code       <= s_axis_tuser[3:2];
            in_item_reg.sample_relative <= s_axis_tuser[4];
            in_item_reg.first_value     <= s_axis_tdata[15:0];
            in_item_reg.second_value    <= s_axis_tdata[31:16];
        end
        if (adv)
        begin
            out_res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {out_res_reg.out_y, out_res_reg.out_x};
    assign m_axis_tuser  = out_res_reg.moved;

`ifndef NO_ASSERTIONS
    // input side stalls only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_vld_reg && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a held result");

    // every processed item produces a result item
    a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> m_axis_tvalid)
        else $error("processed item produced no result");

    // relative/absolute mark changes only on a processed mouse sample
    a_track_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(state_reg.tracking_relative) |->
            ($past(adv) && ($past(in_item_reg.kind) == KIND_MOUSE)))
        else $error("tracking mark changed without a mouse sample");
`endif

endmodule

/* design/pmn_cfg.sv */
// configuration registers of the pointer motion normalizer
// depends on pmn_pkg
`timescale 1ns / 1ps

module pmn_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pmn_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pmn_pkg::CFG_DATA_W-1:0]  cfg_data,
    output pmn_pkg::cfg_t                   cfg
);
    import pmn_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WANT_RELATIVE:  cfg_reg.want_relative  <= cfg_data[0];
                CFG_NO_CLAMP:       cfg_reg.no_clamp       <= cfg_data[0];
                CFG_SURFACE_WIDTH:  cfg_reg.surface_width  <= cfg_data;
                CFG_SURFACE_HEIGHT: cfg_reg.surface_height <= cfg_data;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/pmn_calc.sv */
// per-item logic: next state and result from the current state and one item
// depends on pmn_pkg
`timescale 1ns / 1ps

module pmn_calc (
    input  pmn_pkg::cfg_t    cfg,
    input  pmn_pkg::item_t   item,
    input  pmn_pkg::state_t  cur,
    output pmn_pkg::state_t  nxt,
    output pmn_pkg::result_t res
);
    import pmn_pkg::*;

    logic               do_x;
    logic               do_y;
    logic               report;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    state_t             st;
    result_t            r;

    always_comb
    begin
        do_x   = (item.axis_code == AXIS_X) || (item.axis_code == AXIS_XY);
        do_y   = (item.axis_code == AXIS_Y) || (item.axis_code == AXIS_XY);
        vx     = sext16(item.first_value);
        vy     = (item.axis_code == AXIS_XY) ? sext16(item.second_value) : vx;
        st     = cur;
        r      = '0;
        report = 1'b0;
        dx     = '0;
        dy     = '0;

        case (item.kind)
            KIND_POLL:
            begin
                if (!cur.tracking_relative)
                begin
                    report = 1'b1;
                end
                else
                begin
                    r.moved = 1'b1;
                end
            end
            KIND_MOUSE:
            begin
                // mark change clears history
                if (item.sample_relative != cur.tracking_relative)
                begin
                    st                   = '0;
                    st.tracking_relative = item.sample_relative;
                end
                if (item.axis_code != AXIS_UNKNOWN)
                begin
                    if (item.sample_relative)
                    begin
                        if (cfg.want_relative)
                        begin
                            if (do_x)
                            begin
                                r.out_x       = vx;
                                st.previous_x = vx;
                            end
                            if (do_y)
                            begin
                                r.out_y       = vy;
                                st.previous_y = vy;
                            end
                            r.moved = (r.out_x != 0) || (r.out_y != 0);
                        end
                        else
                        begin
                            if (do_x)
                            begin
                                st.position_x = sat32({st.position_x[31], st.position_x}
                                                      + {vx[31], vx});
                            end
                            if (do_y)
                            begin
                                st.position_y = sat32({st.position_y[31], st.position_y}
                                                      + {vy[31], vy});
                            end
                            report = 1'b1;
                        end
                    end
                    else
                    begin
                        if (!cfg.want_relative)
                        begin
                            if (do_x)
                            begin
                                st.position_x = vx;
                            end
                            if (do_y)
                            begin
                                st.position_y = vy;
                            end
                            report = 1'b1;
                        end
                        else
                        begin
                            if (do_x)
                            begin
                                dx = sat32({vx[31], vx}
                                           - {st.previous_x[31], st.previous_x});
                                st.previous_x = vx;
                            end
                            if (do_y)
                            begin
                                dy = sat32({vy[31], vy}
                                           - {st.previous_y[31], st.previous_y});
                                st.previous_y = vy;
                            end
                            if ((dx != 0) || (dy != 0))
                            begin
                                r.out_x = dx;
                                r.out_y = dy;
                                r.moved = 1'b1;
                            end
                        end
                    end
                end
            end
            default:
            begin
                st = cur;
            end
        endcase

        // clamp, store and report the position
        cx = clamp_axis(st.position_x, cfg.no_clamp, cfg.surface_width);
        cy = clamp_axis(st.position_y, cfg.no_clamp, cfg.surface_height);
        if (report)
        begin
            r.moved       = (st.previous_x != cx) || (st.previous_y != cy);
            r.out_x       = cx;
            r.out_y       = cy;
            st.position_x = cx;
            st.position_y = cy;
            st.previous_x = cx;
            st.previous_y = cy;
        end

        nxt = st;
        res = r;
    end

endmodule

/* test/tb_pointer_motion_normalizer.sv */
// testbench for pointer_motion_normalizer: directed table and random phases per setting,
// checked against literal expectations in the table or an in-bench predictor
// depends on pmn_pkg and the pointer_motion_normalizer rtl
`timescale 1ns / 1ps

module tb_pointer_motion_normalizer;
    import pmn_pkg::*;

    localparam logic [1:0] KIND_OTHER = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef struct {
        bit      is_setting;
        cfg_t    cfg;
        item_t   sample;
        bit      known;
        result_t lit;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // first_value, second_value
    logic [4:0]  s_axis_tuser = '0;   // kind, axis_code, sample_relative
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;        // out_x, out_y
    logic [0:0]  m_axis_tuser;        // moved
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor state and settings
    cfg_t               model_cfg = '0;
    bit                 trk_rel = 1'b0;
    logic signed [31:0] pos_x = '0;
    logic signed [31:0] pos_y = '0;
    logic signed [31:0] hist_x = '0;
    logic signed [31:0] hist_y = '0;

    result_t   awaited_motion[$];
    plan_row_t directed_plan[$];
    int        mismatches = 0;
    bit        no_idle = 1'b0;

    pointer_motion_normalizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb_pointer_motion_normalizer: FAIL");
        $finish;
    end

    function automatic logic signed [31:0] saturate(input longint v);
        logic signed [31:0] r;
        if (v > longint'(32'sh7fffffff))
            r = 32'sh7fffffff;
        else if (v < -longint'(32'sh7fffffff) - 1)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] fit_to_surface(input logic signed [31:0] v,
                                                          input logic [15:0] bound);
        logic signed [31:0] r;
        r = v;
        if (!model_cfg.no_clamp)
        begin
            if (v < 0)
                r = '0;
            else if (longint'(v) > longint'(bound))
                r = {16'd0, bound};
        end
        return r;
    endfunction

    function automatic bit report_position(output logic signed [31:0] ox,
                                           output logic signed [31:0] oy);
        bit changed;
        pos_x = fit_to_surface(pos_x, model_cfg.surface_width);
        pos_y = fit_to_surface(pos_y, model_cfg.surface_height);
        changed = (hist_x != pos_x) || (hist_y != pos_y);
        hist_x = pos_x;
        hist_y = pos_y;
        ox = pos_x;
        oy = pos_y;
        return changed;
    endfunction

    function automatic result_t normalize_item(input item_t it);
        result_t            r;
        logic signed [31:0] vx, vy, dx, dy, ox, oy;
        bit                 do_x, do_y;
        r = '0;
        ox = '0;
        oy = '0;
        do_x = (it.axis_code == AXIS_X) || (it.axis_code == AXIS_XY);
        do_y = (it.axis_code == AXIS_Y) || (it.axis_code == AXIS_XY);
        vx = it.first_value;
        vy = (it.axis_code == AXIS_XY) ? it.second_value : it.first_value;
        if (it.kind == KIND_POLL)
        begin
            if (!trk_rel)
                r.moved = report_position(ox, oy);
            else
                r.moved = 1'b1;
        end
        else if (it.kind == KIND_MOUSE)
        begin
            if (it.sample_relative != trk_rel)
            begin
                trk_rel = it.sample_relative;
                pos_x = '0;
                pos_y = '0;
                hist_x = '0;
                hist_y = '0;
            end
            if (it.axis_code != AXIS_UNKNOWN)
            begin
                if (it.sample_relative)
                begin
                    if (model_cfg.want_relative)
                    begin
                        if (do_x)
                        begin
                            ox = vx;
                            hist_x = vx;
                        end
                        if (do_y)
                        begin
                            oy = vy;
                            hist_y = vy;
                        end
                        r.moved = (ox != 0) || (oy != 0);
                    end
                    else
                    begin
                        if (do_x)
                            pos_x = saturate(longint'(pos_x) + longint'(vx));
                        if (do_y)
                            pos_y = saturate(longint'(pos_y) + longint'(vy));
                        r.moved = report_position(ox, oy);
                    end
                end
                else if (!model_cfg.want_relative)
                begin
                    if (do_x)
                        pos_x = vx;
                    if (do_y)
                        pos_y = vy;
                    r.moved = report_position(ox, oy);
                end
                else
                begin
                    dx = '0;
                    dy = '0;
                    if (do_x)
                    begin
                        dx = saturate(longint'(vx) - longint'(hist_x));
                        hist_x = vx;
                    end
                    if (do_y)
                    begin
                        dy = saturate(longint'(vy) - longint'(hist_y));
                        hist_y = vy;
                    end
                    if (dx != 0 || dy != 0)
                    begin
                        ox = dx;
                        oy = dy;
                        r.moved = 1'b1;
                    end
                end
            end
        end
        r.out_x = ox;
        r.out_y = oy;
        return r;
    endfunction

    function automatic void add_setting(input bit want, input bit nc, input int w, input int h);
        plan_row_t row;
        row = '{default: '0};
        row.is_setting = 1'b1;
        row.cfg.want_relative = want;
        row.cfg.no_clamp = nc;
        row.cfg.surface_width = w[15:0];
        row.cfg.surface_height = h[15:0];
        directed_plan.push_back(row);
    endfunction

    function automatic void add_step(input logic [1:0] kind, input logic [1:0] axis,
                                     input bit rel, input int v0, input int v1,
                                     input bit known, input bit mv, input int ox, input int oy);
        plan_row_t row;
        row = '{default: '0};
        row.sample.kind = kind;
        row.sample.axis_code = axis;
        row.sample.sample_relative = rel;
        row.sample.first_value = v0[15:0];
        row.sample.second_value = v1[15:0];
        row.known = known;
        row.lit.moved = mv;
        row.lit.out_x = ox;
        row.lit.out_y = oy;
        directed_plan.push_back(row);
    endfunction

    function automatic logic [15:0] draw_value();
        logic [15:0] v;
        case ($urandom_range(0, 3))
            0: v = 16'($urandom_range(0, 40)) - 16'd20;
            1: v = 16'($urandom);
            2: v = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: v = 16'($urandom_range(0, 400)) - 16'd50;
        endcase
        return v;
    endfunction

    function automatic item_t draw_item(inout bit mark);
        item_t it;
        int    pick;
        pick = $urandom_range(0, 99);
        it.kind = KIND_MOUSE;
        if (pick < 8)
            it.kind = KIND_POLL;
        else if (pick < 12)
            it.kind = $urandom_range(0, 1) ? KIND_OTHER : KIND_SPARE;
        if ($urandom_range(0, 15) == 0)
            mark = ~mark;
        it.axis_code = ($urandom_range(0, 19) == 0) ? AXIS_UNKNOWN : 2'($urandom_range(0, 2));
        it.sample_relative = (it.kind == KIND_MOUSE) ? mark : 1'($urandom);
        it.first_value = draw_value();
        it.second_value = draw_value();
        return it;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic apply_setting(input cfg_t c);
        s_axis_tvalid <= 1'b0;
        while (awaited_motion.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        write_reg(CFG_WANT_RELATIVE, {15'd0, c.want_relative});
        write_reg(CFG_NO_CLAMP, {15'd0, c.no_clamp});
        write_reg(CFG_SURFACE_WIDTH, c.surface_width);
        write_reg(CFG_SURFACE_HEIGHT, c.surface_height);
        cfg_we <= 1'b0;
        model_cfg = c;
    endtask

    task automatic send_item(input item_t it, input bit known, input result_t lit);
        int      gap;
        result_t r;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {it.second_value, it.first_value};
        s_axis_tuser <= {it.sample_relative, it.axis_code, it.kind};
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = normalize_item(it);
        awaited_motion.push_back(known ? lit : r);
    endtask

    // result side: random stalls, two long hold-offs, in-order checking
    initial
    begin
        int      stall, hold, got;
        result_t seen, want;
        stall = 0;
        hold = 0;
        got = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.moved = m_axis_tuser[0];
                seen.out_x = m_axis_tdata[31:0];
                seen.out_y = m_axis_tdata[63:32];
                got++;
                if (awaited_motion.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item %0d: moved=%0d x=%0d y=%0d",
                                 got, seen.moved, seen.out_x, seen.out_y);
                end
                else
                begin
                    want = awaited_motion.pop_front();
                    if (want.moved !== seen.moved || want.out_x !== seen.out_x
                        || want.out_y !== seen.out_y)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("item %0d: expected moved=%0d x=%0d y=%0d, got moved=%0d x=%0d y=%0d",
                                     got, want.moved, want.out_x, want.out_y,
                                     seen.moved, seen.out_x, seen.out_y);
                    end
                end
                stall = no_idle ? 0 : $urandom_range(0, 6);
                if (got == 300 || got == 800)
                    hold = 120;
            end
            if (hold != 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else if (stall != 0)
            begin
                stall--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        cfg_t    c;
        item_t   it;
        result_t none;
        bit      mark;
        int      done;
        none = '0;
        mark = 1'b0;

        // reset settings: everything clamps to the origin
        add_step(KIND_OTHER, AXIS_XY, 1, 123, -7, 1, 0, 0, 0);
        add_step(KIND_SPARE, AXIS_UNKNOWN, 1, -1, -1, 1, 0, 0, 0);
        add_step(KIND_POLL, AXIS_X, 0, 0, 0, 1, 0, 0, 0);
        add_step(KIND_MOUSE, AXIS_XY, 0, 100, -5, 1, 0, 0, 0);
        add_step(KIND_MOUSE, AXIS_UNKNOWN, 1, 9, 9, 1, 0, 0, 0);
        add_step(KIND_POLL, AXIS_Y, 1, 0, 0, 1, 1, 0, 0);
        add_step(KIND_MOUSE, AXIS_XY, 1, 7, 7, 1, 0, 0, 0);
        // deltas on a full surface
        add_setting(1, 0, 65535, 65535);
        add_step(KIND_MOUSE, AXIS_XY, 1, 32767, -32768, 1, 1, 32767, -32768);
        add_step(KIND_MOUSE, AXIS_X, 1, 5, 1234, 1, 1, 5, 0);
        add_step(KIND_MOUSE, AXIS_Y, 1, 0, 99, 1, 0, 0, 0);
        add_step(KIND_MOUSE, AXIS_Y, 1, -1, 0, 1, 1, 0, -1);
        add_step(KIND_MOUSE, AXIS_X, 0, -32768, 0, 1, 1, -32768, 0);
        add_step(KIND_MOUSE, AXIS_X, 0, -32768, 0, 1, 0, 0, 0);
        add_step(KIND_MOUSE, AXIS_XY, 0, 32767, 32767, 1, 1, 65535, 32767);
        add_step(KIND_MOUSE, AXIS_Y, 0, 32767, -1, 1, 0, 0, 0);
        add_step(KIND_POLL, AXIS_XY, 0, 0, 0, 0, 0, 0, 0);
        // positions on a small surface
        add_setting(0, 0, 100, 50);
        add_step(KIND_MOUSE, AXIS_XY, 0, 200, -3, 0, 0, 0, 0);
        add_step(KIND_MOUSE, AXIS_X, 0, 40, 0, 0, 0, 0, 0);
        add_step(KIND_MOUSE, AXIS_XY, 1, 30, 30, 0, 0, 0, 0);
        add_step(KIND_MOUSE, AXIS_X, 1, 100, 0, 0, 0, 0, 0);
        // clamping off
        add_setting(0, 1, 0, 0);
        add_step(KIND_MOUSE, AXIS_XY, 1, -32768, -32768, 0, 0, 0, 0);
        add_step(KIND_POLL, AXIS_X, 1, 0, 0, 1, 1, 0, 0);
        add_step(KIND_MOUSE, AXIS_XY, 0, -32768, 32767, 1, 1, -32768, 32767);
        add_setting(0, 0, 0, 0);
        add_step(KIND_POLL, AXIS_XY, 0, 0, 0, 0, 0, 0, 0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].is_setting)
                apply_setting(directed_plan[i].cfg);
            else
                send_item(directed_plan[i].sample, directed_plan[i].known, directed_plan[i].lit);
        end

        for (int phase = 0; phase < 8; phase++)
        begin
            c.want_relative = (phase == 1 || phase == 4) ? 1'b1 : 1'b0;
            c.no_clamp = (phase == 2 || phase == 4) ? 1'b1 : 1'b0;
            c.surface_width = 16'($urandom);
            c.surface_height = 16'($urandom);
            case (phase)
                0:
                begin
                    c.surface_width = 16'hffff;
                    c.surface_height = 16'hffff;
                end
                1, 5:
                begin
                    c.surface_width = '0;
                    c.surface_height = '0;
                end
                3:
                begin
                    c.surface_width = 16'($urandom_range(0, 300));
                    c.surface_height = 16'($urandom_range(0, 300));
                end
                6, 7:
                begin
                    c.want_relative = 1'($urandom);
                    c.no_clamp = 1'($urandom);
                end
                default:
                begin
                end
            endcase
            apply_setting(c);
            no_idle = (phase == 6);
            done = 0;
            while (done < 145)
            begin
                it = draw_item(mark);
                send_item(it, 1'b0, none);
                if (it.kind == KIND_MOUSE || it.kind == KIND_POLL)
                    done++;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (awaited_motion.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb_pointer_motion_normalizer: PASS");
        else
            $display("tb_pointer_motion_normalizer: FAIL");
        $finish;
    end

endmodule
